[src/ttpg_pkg.sv]
// shared types, constants and helpers for the timed tone pwm generator
package ttpg_pkg;

   localparam int OPCODE_W = 2;
   localparam int FREQ_W = 16;
   localparam int MS_W = 16;
   localparam int DUTY_W = 7;
   localparam int CNT_W = 16;

   // divider operand width, holds the tick rate
   localparam int DIV_W = 32;
   localparam int DIVISOR_W = 16;

   // reciprocal scaling for the divisions by 100 and by 1000
   // scaled operands stay below 2^27, exact for the full parameter ranges
   localparam int SCALED_W = 27;
   localparam int RECIP_W = 28;
   localparam int PROD_W = SCALED_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_PERCENT = 28'd10737419;
   localparam int PERCENT_SHIFT = 30;
   localparam logic [RECIP_W-1:0] RECIP_MS = 28'd137438954;
   localparam int MS_SHIFT = 37;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [OPCODE_W-1:0] OP_TICK = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_BEEP = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_STOP = 2'd2;

   localparam logic [DUTY_W-1:0] DUTY_RESET = 7'd50;
   localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;
   localparam logic [MS_W-1:0] MS_MIN = 16'd1;

   localparam logic [CNT_W-1:0] TOP_RESET = 16'd999;
   localparam logic [DIVISOR_W-1:0] PERCENT_DIV = 16'd100;
   localparam logic [DIVISOR_W-1:0] MS_PER_SEC = 16'd1000;
   localparam logic [SCALED_W-1:0] ROUND_HALF = 27'd500;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_BEEP,
      CMD_STOP,
      CMD_NOP
   } cmd_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [FREQ_W-1:0]  freq;
      logic [MS_W-1:0]    ms;
      logic [DUTY_W-1:0]  duty;
   } queue_entry_type;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_TOP_WAIT,
      ST_PULSE_MUL,
      ST_PULSE_DIV,
      ST_PER_MUL,
      ST_PER_DIV
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [CNT_W-1:0] sat16(input logic [DIV_W-1:0] v);
      logic [CNT_W-1:0] r;
      r = (v > DIV_W'({CNT_W{1'b1}})) ? {CNT_W{1'b1}} : v[CNT_W-1:0];
      return r;
   endfunction

endpackage

[src/ttpg_if.sv]
// request and response channel interfaces
interface ttpg_req_if import ttpg_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [FREQ_W-1:0]   freq_hz;
   logic [MS_W-1:0]     duration_ms;

   modport source (output valid, output opcode, output freq_hz, output duration_ms,
                   input ready);
   modport sink (input valid, input opcode, input freq_hz, input duration_ms,
                 output ready);
endinterface

interface ttpg_rsp_if ();
   logic valid;
   logic ready;
   logic tone_out;
   logic busy_res;
   logic finished;

   modport source (output valid, output tone_out, output busy_res, output finished,
                   input ready);
   modport sink (input valid, input tone_out, input busy_res, input finished,
                 output ready);
endinterface

[src/ttpg_front.sv]
// front end: accepts items, clamps fields, holds the duty register, classifies
module ttpg_front import ttpg_pkg::*; #(
   parameter int unsigned FREQ_MIN = 100,
   parameter int unsigned FREQ_MAX = 10000,
   parameter int unsigned DURATION_MAX = 5000
) (
   input  logic             clock,
   input  logic             reset,
   ttpg_req_if.sink         req_bus,
   input  logic             csr_wr_en,
   input  logic [DUTY_W-1:0] csr_wr_data,
   input  logic             q_ready,
   output logic             q_push,
   output queue_entry_type  q_entry
);

   logic [DUTY_W-1:0] duty_ff;
   logic [DUTY_W-1:0] duty_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff <= DUTY_RESET;
      end else begin
         duty_ff <= duty_in;
      end
   end

   assign duty_in = csr_wr_en ? csr_wr_data : duty_ff;

   assign req_bus.ready = q_ready;
   assign q_push = req_bus.valid && q_ready;

   always_comb begin
      case (req_bus.opcode)
         OP_TICK: q_entry.cmd = CMD_TICK;
         OP_BEEP: q_entry.cmd = CMD_BEEP;
         OP_STOP: q_entry.cmd = CMD_STOP;
         default: q_entry.cmd = CMD_NOP;
      endcase

      if (req_bus.freq_hz < FREQ_W'(FREQ_MIN)) begin
         q_entry.freq = FREQ_W'(FREQ_MIN);
      end else if (req_bus.freq_hz > FREQ_W'(FREQ_MAX)) begin
         q_entry.freq = FREQ_W'(FREQ_MAX);
      end else begin
         q_entry.freq = req_bus.freq_hz;
      end

      if (req_bus.duration_ms < MS_MIN) begin
         q_entry.ms = MS_MIN;
      end else if (req_bus.duration_ms > MS_W'(DURATION_MAX)) begin
         q_entry.ms = MS_W'(DURATION_MAX);
      end else begin
         q_entry.ms = req_bus.duration_ms;
      end

      // duty above full scale acts as full scale
      q_entry.duty = (duty_ff > DUTY_MAX) ? DUTY_MAX : duty_ff;
   end

endmodule

[src/ttpg_queue.sv]
// short command queue between the front end and the back end
module ttpg_queue import ttpg_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   output logic            push_ready,
   input  logic            pop,
   output logic            head_valid,
   output queue_entry_type head_entry
);

   queue_entry_type          entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff;
   logic [QUEUE_CNT_W-1:0]   count_in;
   logic                     do_push;
   logic                     do_pop;

   assign push_ready = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = entries_ff[rd_ptr_ff];
   assign do_push = push && push_ready;
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[src/ttpg_div.sv]
// restoring divider, one quotient bit per cycle
module ttpg_div import ttpg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int STEP_W = $clog2(DIV_W + 1);

   logic [DIVISOR_W-1:0] rem_ff;
   logic [DIVISOR_W-1:0] rem_in;
   logic [DIV_W-1:0]     quo_ff;
   logic [DIV_W-1:0]     quo_in;
   logic [DIVISOR_W-1:0] divisor_ff;
   logic [DIVISOR_W-1:0] divisor_in;
   logic [STEP_W-1:0]    steps_ff;
   logic [STEP_W-1:0]    steps_in;
   logic                 busy_ff;
   logic                 busy_in;
   logic                 done_ff;
   logic                 done_in;
   logic [DIVISOR_W:0]   shifted;
   logic [DIVISOR_W:0]   diff;

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign diff = shifted - {1'b0, divisor_ff};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      divisor_in = divisor_ff;
      steps_in = steps_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in = '0;
         quo_in = req.dividend;
         divisor_in = req.divisor;
         steps_in = STEP_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the shifted trial fits one extra bit
         if (shifted >= {1'b0, divisor_ff}) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         steps_in = steps_ff - 1'b1;
         if (steps_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         steps_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         steps_ff <= steps_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

[src/ttpg_back.sv]
// back end: runs the tone counters, sequences beep setup
module ttpg_back import ttpg_pkg::*; #(
   parameter int unsigned TICK_HZ = 1000000
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  queue_entry_type head_entry,
   output logic            pop,
   ttpg_rsp_if.source      rsp_bus
);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     period_top_ff, period_top_in;
   logic [CNT_W-1:0]     pulse_width_ff, pulse_width_in;
   logic [CNT_W-1:0]     tick_count_ff, tick_count_in;
   logic [CNT_W-1:0]     periods_left_ff, periods_left_in;
   logic                 running_ff, running_in;
   logic [FREQ_W-1:0]    freq_ff, freq_in;
   logic [MS_W-1:0]      ms_ff, ms_in;
   logic [DUTY_W-1:0]    duty_ff, duty_in;
   logic [DIV_W-1:0]     dividend_ff, dividend_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [SCALED_W-1:0]  scaled_ff, scaled_in;
   logic                 div_start_ff, div_start_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_tone_ff, out_tone_in;
   logic                 out_busy_ff, out_busy_in;
   logic                 out_fin_ff, out_fin_in;

   logic                 out_free;
   logic [CNT_W-1:0]     left_dec;
   logic [CNT_W:0]       top_plus;
   logic [RECIP_W-1:0]   recip;
   logic [PROD_W-1:0]    recip_prod;
   logic [PROD_W-PERCENT_SHIFT-1:0] pulse_quo;
   logic [PROD_W-MS_SHIFT-1:0]      per_quo;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   ttpg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign div_req.start = div_start_ff;
   assign div_req.dividend = dividend_ff;
   assign div_req.divisor = divisor_ff;

   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign left_dec = (periods_left_ff != '0) ? periods_left_ff - 1'b1 : '0;
   assign top_plus = {1'b0, period_top_ff} + 1'b1;

   // one multiplier serves both constant divisions
   assign recip = (state_ff == ST_PER_DIV) ? RECIP_MS : RECIP_PERCENT;
   assign recip_prod = {{RECIP_W{1'b0}}, scaled_ff} * {{SCALED_W{1'b0}}, recip};
   assign pulse_quo = recip_prod[PROD_W-1:PERCENT_SHIFT];
   assign per_quo = recip_prod[PROD_W-1:MS_SHIFT];

   always_comb begin
      state_in = state_ff;
      period_top_in = period_top_ff;
      pulse_width_in = pulse_width_ff;
      tick_count_in = tick_count_ff;
      periods_left_in = periods_left_ff;
      running_in = running_ff;
      freq_in = freq_ff;
      ms_in = ms_ff;
      duty_in = duty_ff;
      dividend_in = dividend_ff;
      divisor_in = divisor_ff;
      scaled_in = scaled_ff;
      div_start_in = 1'b0;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_tone_in = out_tone_ff;
      out_busy_in = out_busy_ff;
      out_fin_in = out_fin_ff;
      pop = 1'b0;

      case (state_ff)
         ST_RUN: begin
            if (head_valid && out_free) begin
               pop = 1'b1;
               case (head_entry.cmd)
                  CMD_TICK: begin
                     out_valid_in = 1'b1;
                     out_tone_in = 1'b0;
                     out_fin_in = 1'b0;
                     if (running_ff) begin
                        out_tone_in = tick_count_ff < pulse_width_ff;
                        if (tick_count_ff >= period_top_ff) begin
                           tick_count_in = '0;
                           periods_left_in = left_dec;
                           if (left_dec == '0) begin
                              // last period ends: output forced low
                              running_in = 1'b0;
                              out_tone_in = 1'b0;
                              out_fin_in = 1'b1;
                           end
                        end else begin
                           tick_count_in = tick_count_ff + 1'b1;
                        end
                     end
                     out_busy_in = running_in;
                  end
                  CMD_BEEP: begin
                     freq_in = head_entry.freq;
                     ms_in = head_entry.ms;
                     duty_in = head_entry.duty;
                     dividend_in = DIV_W'(TICK_HZ);
                     divisor_in = head_entry.freq;
                     div_start_in = 1'b1;
                     state_in = ST_TOP_WAIT;
                  end
                  CMD_STOP: begin
                     running_in = 1'b0;
                     periods_left_in = '0;
                     out_valid_in = 1'b1;
                     out_tone_in = 1'b0;
                     out_busy_in = 1'b0;
                     out_fin_in = 1'b0;
                  end
                  default: begin
                     out_valid_in = 1'b1;
                     out_tone_in = 1'b0;
                     out_busy_in = running_ff;
                     out_fin_in = 1'b0;
                  end
               endcase
            end
         end
         ST_TOP_WAIT: begin
            if (div_rsp.done) begin
               period_top_in = (div_rsp.quotient == '0) ? '0 :
                               sat16(div_rsp.quotient - 1'b1);
               state_in = ST_PULSE_MUL;
            end
         end
         ST_PULSE_MUL: begin
            scaled_in = {{(SCALED_W-CNT_W-1){1'b0}}, top_plus} *
                        {{(SCALED_W-DUTY_W){1'b0}}, duty_ff};
            state_in = ST_PULSE_DIV;
         end
         ST_PULSE_DIV: begin
            pulse_width_in = sat16(DIV_W'(pulse_quo));
            state_in = ST_PER_MUL;
         end
         ST_PER_MUL: begin
            // rounded period count: (f * ms + 500) / 1000
            scaled_in = {{(SCALED_W-FREQ_W){1'b0}}, freq_ff} *
                        {{(SCALED_W-MS_W){1'b0}}, ms_ff} + ROUND_HALF;
            state_in = ST_PER_DIV;
         end
         ST_PER_DIV: begin
            periods_left_in = (per_quo == '0) ? CNT_W'(1) : sat16(DIV_W'(per_quo));
            tick_count_in = '0;
            running_in = 1'b1;
            out_valid_in = 1'b1;
            out_tone_in = 1'b0;
            out_busy_in = 1'b1;
            out_fin_in = 1'b0;
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         period_top_ff <= TOP_RESET;
         pulse_width_ff <= '0;
         tick_count_ff <= '0;
         periods_left_ff <= '0;
         running_ff <= 1'b0;
         div_start_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         period_top_ff <= period_top_in;
         pulse_width_ff <= pulse_width_in;
         tick_count_ff <= tick_count_in;
         periods_left_ff <= periods_left_in;
         running_ff <= running_in;
         div_start_ff <= div_start_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      freq_ff <= freq_in;
      ms_ff <= ms_in;
      duty_ff <= duty_in;
      dividend_ff <= dividend_in;
      divisor_ff <= divisor_in;
      scaled_ff <= scaled_in;
      out_tone_ff <= out_tone_in;
      out_busy_ff <= out_busy_in;
      out_fin_ff <= out_fin_in;
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.tone_out = out_tone_ff;
   assign rsp_bus.busy_res = out_busy_ff;
   assign rsp_bus.finished = out_fin_ff;

   a_run_has_periods: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> periods_left_ff != '0)
      else $error("tone running with no periods left");

   a_fin_not_busy: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_fin_ff) |-> (!out_busy_ff && !out_tone_ff))
      else $error("finished result still busy or high");

   a_tone_needs_busy: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_tone_ff) |-> out_busy_ff)
      else $error("tone high on a silent result");

   a_no_pop_in_setup: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_RUN) |-> !pop)
      else $error("queue popped during beep setup");

   a_setup_result_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PER_DIV) |-> !out_valid_ff)
      else $error("result slot occupied during beep setup");

endmodule

[src/timed_tone_pwm_generator_top.sv]
// top level of the timed tone pwm generator
//
// req_bus carries items: opcode 0 is one timer tick, 1 starts a beep with
// freq_hz and duration_ms, 2 stops the tone, 3 is ignored. every item
// gives exactly one result on rsp_bus: tone_out, busy_res, finished.
// csr_wr_en/csr_wr_data write duty_percent, which a beep samples.
//
// items go through a two-entry queue into the back end, so req_bus keeps
// taking items while a result waits on a stalled receiver.
// ticks, stops and ignored items are each handled in the run state, so a
// tick stream runs at one item per cycle while rsp_bus.ready stays high;
// a result reaches rsp_bus through the queue and then the result register.
// a beep holds the back end for one 32-step pass of the serial divider
// for the period top, then a multiply and a reciprocal multiply each for
// the pulse width and the period count.
// when rsp_bus.ready is low the result register holds, the queue fills,
// then req_bus.ready drops.
// reset (synchronous, active high) empties the queue, silences the tone,
// sets period top to 999 and duty to 50 percent.
module timed_tone_pwm_generator_top import ttpg_pkg::*; #(
   parameter int unsigned TICK_HZ = 1000000,
   parameter int unsigned FREQ_MIN = 100,
   parameter int unsigned FREQ_MAX = 10000,
   parameter int unsigned DURATION_MAX = 5000
) (
   input  logic              clock,
   input  logic              reset,
   ttpg_req_if.sink          req_bus,
   ttpg_rsp_if.source        rsp_bus,
   input  logic              csr_wr_en,
   input  logic [DUTY_W-1:0] csr_wr_data
);

   logic            q_push;
   logic            q_ready;
   queue_entry_type q_entry;
   logic            head_valid;
   queue_entry_type head_entry;
   logic            pop;

   ttpg_front #(
      .FREQ_MIN     (FREQ_MIN),
      .FREQ_MAX     (FREQ_MAX),
      .DURATION_MAX (DURATION_MAX)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_ready     (q_ready),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   ttpg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .push_ready (q_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   ttpg_back #(
      .TICK_HZ (TICK_HZ)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

[bench/timed_tone_pwm_generator_checker.sv]
`timescale 1ns / 1ps
// scoreboard that predicts every tone generator result and compares it on arrival
module timed_tone_pwm_generator_checker import ttpg_pkg::*; #(
   parameter int unsigned TICK_HZ = 1000000,
   parameter int unsigned FREQ_MIN = 100,
   parameter int unsigned FREQ_MAX = 10000,
   parameter int unsigned DURATION_MAX = 5000
) (
   input  logic              clock,
   input  logic              reset,
   ttpg_req_if               req_bus,
   ttpg_rsp_if               rsp_bus,
   input  logic              csr_wr_en,
   input  logic [DUTY_W-1:0] csr_wr_data,
   output int unsigned       mismatch_count,
   output int unsigned       pending_count
);

   typedef struct packed {
      logic tone_out;
      logic busy_res;
      logic finished;
   } tone_result_type;

   tone_result_type expected_tones[$];

   // shadow copy of the generator state
   logic [DUTY_W-1:0] duty_shadow;
   logic [CNT_W-1:0]  top_shadow;
   logic [CNT_W-1:0]  pulse_shadow;
   logic [CNT_W-1:0]  count_shadow;
   logic [CNT_W-1:0]  left_shadow;
   logic              sounding;

   function automatic logic [CNT_W-1:0] clamp16(input longint unsigned v);
      return (v > 64'd65535) ? {CNT_W{1'b1}} : CNT_W'(v);
   endfunction

   task automatic load_tone(input logic [FREQ_W-1:0] freq_req, input logic [MS_W-1:0] ms_req);
      longint unsigned f;
      longint unsigned ms;
      longint unsigned duty;
      longint unsigned top;
      longint unsigned periods;
      f = freq_req;
      ms = ms_req;
      duty = (duty_shadow > DUTY_MAX) ? DUTY_MAX : duty_shadow;
      if (f < FREQ_MIN) f = FREQ_MIN;
      if (f > FREQ_MAX) f = FREQ_MAX;
      if (ms < MS_MIN) ms = MS_MIN;
      if (ms > DURATION_MAX) ms = DURATION_MAX;
      top = TICK_HZ / f;
      top = (top > 0) ? top - 1 : 0;
      top_shadow = clamp16(top);
      top = top_shadow;
      pulse_shadow = clamp16((top + 1) * duty / PERCENT_DIV);
      periods = (f * ms + ROUND_HALF) / MS_PER_SEC;
      if (periods == 0) periods = 1;
      left_shadow = clamp16(periods);
      count_shadow = '0;
      sounding = 1'b1;
   endtask

   task automatic step_tone(input cmd_type op, input logic [FREQ_W-1:0] freq,
                            input logic [MS_W-1:0] ms, output tone_result_type r);
      logic level;
      logic done;
      level = 1'b0;
      done = 1'b0;
      case (op)
         CMD_TICK: begin
            if (sounding) begin
               level = count_shadow < pulse_shadow;
               if (count_shadow >= top_shadow) begin
                  count_shadow = '0;
                  if (left_shadow != 0) left_shadow = left_shadow - 1'b1;
                  // last period done: output forced low
                  if (left_shadow == 0) begin
                     sounding = 1'b0;
                     level = 1'b0;
                     done = 1'b1;
                  end
               end else begin
                  count_shadow = count_shadow + 1'b1;
               end
            end
         end
         CMD_BEEP: begin
            load_tone(freq, ms);
         end
         CMD_STOP: begin
            sounding = 1'b0;
            left_shadow = '0;
         end
         default: begin
         end
      endcase
      r.tone_out = level;
      r.busy_res = sounding;
      r.finished = done;
   endtask

   always @(posedge clock) begin
      tone_result_type got;
      tone_result_type want;
      if (reset) begin
         duty_shadow = DUTY_RESET;
         top_shadow = TOP_RESET;
         pulse_shadow = '0;
         count_shadow = '0;
         left_shadow = '0;
         sounding = 1'b0;
         expected_tones.delete();
         mismatch_count = 0;
      end else begin
         if (csr_wr_en) duty_shadow = csr_wr_data;
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.tone_out = rsp_bus.tone_out;
            got.busy_res = rsp_bus.busy_res;
            got.finished = rsp_bus.finished;
            if (expected_tones.size() == 0) begin
               $error("result with no item pending: tone_out %0b busy_res %0b finished %0b",
                      got.tone_out, got.busy_res, got.finished);
               mismatch_count++;
            end else begin
               want = expected_tones.pop_front();
               if (got.tone_out !== want.tone_out) begin
                  $error("tone_out mismatch: expected %0b, actual %0b",
                         want.tone_out, got.tone_out);
                  mismatch_count++;
               end
               if (got.busy_res !== want.busy_res) begin
                  $error("busy_res mismatch: expected %0b, actual %0b",
                         want.busy_res, got.busy_res);
                  mismatch_count++;
               end
               if (got.finished !== want.finished) begin
                  $error("finished mismatch: expected %0b, actual %0b",
                         want.finished, got.finished);
                  mismatch_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            step_tone(cmd_type'(req_bus.opcode), req_bus.freq_hz, req_bus.duration_ms, want);
            expected_tones.push_back(want);
         end
      end
      pending_count = expected_tones.size();
   end

endmodule

[bench/timed_tone_pwm_generator_top_tb.sv]
`timescale 1ns / 1ps
// stimulus, clock, reset and verdict for the timed tone pwm generator
module timed_tone_pwm_generator_top_tb;
   import ttpg_pkg::*;

   localparam int unsigned TICK_HZ = 1000000;
   localparam int unsigned FREQ_MIN = 100;
   localparam int unsigned FREQ_MAX = 10000;
   localparam int unsigned DURATION_MAX = 5000;

   // four random phases share the random item budget equally
   localparam int unsigned RANDOM_ITEMS = 1040;
   localparam int unsigned PHASE_ITEMS = RANDOM_ITEMS / 4;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   // highest rate whose one-ms tone is still a single period
   localparam int unsigned SHORT_TONE_HZ = 1499;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [DUTY_W-1:0] csr_wr_data = '0;

   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned hold_off_left = 0;

   ttpg_req_if req_bus ();
   ttpg_rsp_if rsp_bus ();

   timed_tone_pwm_generator_top #(
      .TICK_HZ(TICK_HZ),
      .FREQ_MIN(FREQ_MIN),
      .FREQ_MAX(FREQ_MAX),
      .DURATION_MAX(DURATION_MAX)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   timed_tone_pwm_generator_checker #(
      .TICK_HZ(TICK_HZ),
      .FREQ_MIN(FREQ_MIN),
      .FREQ_MAX(FREQ_MAX),
      .DURATION_MAX(DURATION_MAX)
   ) tone_checker (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .mismatch_count(mismatch_count),
      .pending_count(pending_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_off_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_off_left = hold_off_left - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
      end
   end

   function automatic int unsigned clip_count(input int unsigned n, input int unsigned limit);
      return (n < limit) ? n : limit;
   endfunction

   task automatic send_item(input cmd_type op, input logic [FREQ_W-1:0] freq,
                            input logic [MS_W-1:0] ms);
      @(negedge clock);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op;
      req_bus.freq_hz <= freq;
      req_bus.duration_ms <= ms;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   // tick fields are don't-care, so they carry random noise
   task automatic send_ticks(input int unsigned n);
      repeat (n) send_item(CMD_TICK, FREQ_W'($urandom), MS_W'($urandom));
   endtask

   task automatic send_random_beep;
      logic [FREQ_W-1:0] freq;
      logic [MS_W-1:0]   ms;
      case ($urandom_range(7, 0))
         0: freq = FREQ_W'($urandom);
         1: freq = FREQ_W'($urandom_range(FREQ_MIN + 5, 0));
         2: freq = FREQ_W'($urandom_range(FREQ_MAX + 50, FREQ_MAX - 5));
         default: freq = FREQ_W'($urandom_range(FREQ_MAX, 2000));
      endcase
      case ($urandom_range(3, 0))
         0: ms = MS_W'($urandom);
         1: ms = MS_W'($urandom_range(2, 0));
         2: ms = MS_W'($urandom_range(DURATION_MAX + 10, DURATION_MAX - 10));
         default: ms = MS_W'($urandom_range(3000, 1));
      endcase
      send_item(CMD_BEEP, freq, ms);
   endtask

   // drop valid and wait until every result is back
   task automatic drain;
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_duty(input logic [DUTY_W-1:0] duty);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= duty;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input logic [DUTY_W-1:0] duty, input int unsigned idle_pct,
                            input int unsigned stall_pct, input int unsigned hold_cycles);
      int unsigned first_item;
      int unsigned pick;
      int unsigned budget;
      write_duty(duty);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      hold_off_left = hold_cycles;
      first_item = items_sent;
      while (items_sent - first_item < PHASE_ITEMS) begin
         budget = PHASE_ITEMS - (items_sent - first_item);
         pick = $urandom_range(99, 0);
         if (pick < 60) begin
            send_random_beep();
            send_ticks(clip_count($urandom_range(250, 1), budget - 1));
         end else if (pick < 70) begin
            send_item(CMD_STOP, FREQ_W'($urandom), MS_W'($urandom));
            send_ticks(clip_count($urandom_range(8, 1), budget - 1));
         end else if (pick < 78) begin
            repeat (clip_count($urandom_range(4, 1), budget))
               send_item(CMD_NOP, FREQ_W'($urandom), MS_W'($urandom));
         end else begin
            send_ticks(clip_count($urandom_range(40, 1), budget));
         end
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_TICK;
      req_bus.freq_hz = '0;
      req_bus.duration_ms = '0;
      rsp_bus.ready = 1'b0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // directed part at the reset duty
      send_item(CMD_TICK, '1, '1);
      send_item(CMD_NOP, '1, '1);
      send_item(CMD_STOP, '0, '0);
      send_item(CMD_BEEP, '0, '0);
      send_ticks(3);
      // beep during a tone restarts it
      send_item(CMD_BEEP, '1, '1);
      send_ticks(120);
      send_item(CMD_BEEP, FREQ_W'(FREQ_MIN - 1), MS_W'(DURATION_MAX + 1));
      send_ticks(2);
      send_item(CMD_BEEP, FREQ_W'(FREQ_MAX + 1), MS_MIN);
      send_item(CMD_BEEP, FREQ_W'(FREQ_MIN), MS_W'(DURATION_MAX));
      send_item(CMD_NOP, '0, '0);
      send_item(CMD_STOP, '1, '1);
      send_ticks(2);
      // one-period tone run all the way to its final wrap
      send_item(CMD_BEEP, FREQ_W'(SHORT_TONE_HZ), MS_MIN);
      send_ticks(TICK_HZ / SHORT_TONE_HZ + 2);

      run_phase('0, 0, 0, HOLD_OFF_CYCLES);
      run_phase(DUTY_MAX, 51, 0, 0);
      run_phase('1, 0, 51, 0);
      run_phase(DUTY_W'($urandom_range(127, 0)), 21, 21, 0);

      drain();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
